// ===== rtl/core/chd_pkg.sv =====
package chd_pkg;

  localparam int LenBits = 32;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChSemi  = 8'd59;
  localparam logic [7:0] ChSpace = 8'd32;

  localparam logic [2:0] KindFrame   = 3'd0;
  localparam logic [2:0] KindPayload = 3'd1;
  localparam logic [2:0] KindEnd     = 3'd2;
  localparam logic [2:0] KindIgnored = 3'd3;
  localparam logic [2:0] KindError   = 3'd4;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrCr       = 3'd1;
  localparam logic [2:0] ErrLf       = 3'd2;
  localparam logic [2:0] ErrSize     = 3'd3;
  localparam logic [2:0] ErrOverflow = 3'd4;

  typedef enum logic [12:0] {
    PH_CHUNK_CR   = 13'b0000000000001,
    PH_CHUNK_LF   = 13'b0000000000010,
    PH_SIZE_FIRST = 13'b0000000000100,
    PH_SIZE_MORE  = 13'b0000000001000,
    PH_EXT        = 13'b0000000010000,
    PH_SIZE_LF    = 13'b0000000100000,
    PH_PAYLOAD    = 13'b0000001000000,
    PH_TR_START   = 13'b0000010000000,
    PH_TR_TEXT    = 13'b0000100000000,
    PH_TR_LF      = 13'b0001000000000,
    PH_FINAL_LF   = 13'b0010000000000,
    PH_DONE       = 13'b0100000000000,
    PH_ERROR      = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
    logic [2:0] err;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'd48:8'd57]}) begin
      r = {1'b1, 4'(c - 8'd48)};
    end else if (c inside {[8'd65:8'd70]}) begin
      r = {1'b1, 4'(c - 8'd55)};
    end else if (c inside {[8'd97:8'd102]}) begin
      r = {1'b1, 4'(c - 8'd87)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/chd_decode.sv =====
module chd_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [7:0]               byte_in,
  output chd_pkg::result_t         res
);

  chd_pkg::phase_t                phase, phase_next;
  logic [chd_pkg::LenBits-1:0]    remaining_count, remaining_count_next;
  logic [2:0]                     error_reason, error_reason_next;

  always_comb begin
    logic [4:0] hx;
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    hx                   = chd_pkg::hex_decode(byte_in);
    phase_next           = phase;
    remaining_count_next = remaining_count;
    error_reason_next    = error_reason;
    kind                 = chd_pkg::KindFrame;
    data                 = 8'd0;
    last                 = 1'b0;
    case (phase)
      chd_pkg::PH_CHUNK_CR: begin
        if (byte_in != chd_pkg::ChCr) begin
          error_reason_next = chd_pkg::ErrCr;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end else begin
          phase_next = chd_pkg::PH_CHUNK_LF;
        end
      end
      chd_pkg::PH_CHUNK_LF: begin
        if (byte_in != chd_pkg::ChLf) begin
          error_reason_next = chd_pkg::ErrLf;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end else begin
          phase_next = chd_pkg::PH_SIZE_FIRST;
        end
      end
      chd_pkg::PH_SIZE_FIRST: begin
        if (hx[4]) begin
          remaining_count_next = chd_pkg::LenBits'(hx[3:0]);
          phase_next           = chd_pkg::PH_SIZE_MORE;
        end else if (byte_in != chd_pkg::ChSpace) begin
          error_reason_next = chd_pkg::ErrSize;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end
      end
      chd_pkg::PH_SIZE_MORE: begin
        if (hx[4]) begin
          if (remaining_count[chd_pkg::LenBits-1 -: 4] != 4'd0) begin
            error_reason_next = chd_pkg::ErrOverflow;
            phase_next        = chd_pkg::PH_ERROR;
            kind              = chd_pkg::KindError;
          end else begin
            remaining_count_next = {remaining_count[chd_pkg::LenBits-5:0], hx[3:0]};
          end
        end else if (byte_in == chd_pkg::ChSemi) begin
          phase_next = chd_pkg::PH_EXT;
        end else if (byte_in == chd_pkg::ChCr) begin
          phase_next = chd_pkg::PH_SIZE_LF;
        end else if (byte_in != chd_pkg::ChSpace) begin
          error_reason_next = chd_pkg::ErrSize;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end
      end
      chd_pkg::PH_EXT: begin
        if (byte_in == chd_pkg::ChCr) begin
          phase_next = chd_pkg::PH_SIZE_LF;
        end
      end
      chd_pkg::PH_SIZE_LF: begin
        if (byte_in != chd_pkg::ChLf) begin
          error_reason_next = chd_pkg::ErrLf;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end else if (remaining_count != '0) begin
          phase_next = chd_pkg::PH_PAYLOAD;
        end else begin
          phase_next = chd_pkg::PH_TR_START;
        end
      end
      chd_pkg::PH_PAYLOAD: begin
        kind                 = chd_pkg::KindPayload;
        data                 = byte_in;
        remaining_count_next = remaining_count - chd_pkg::LenBits'(1);
        if (remaining_count_next == '0) begin
          last       = 1'b1;
          phase_next = chd_pkg::PH_CHUNK_CR;
        end
      end
      chd_pkg::PH_TR_START: begin
        if (byte_in == chd_pkg::ChCr) begin
          phase_next = chd_pkg::PH_FINAL_LF;
        end else begin
          phase_next = chd_pkg::PH_TR_TEXT;
        end
      end
      chd_pkg::PH_TR_TEXT: begin
        if (byte_in == chd_pkg::ChCr) begin
          phase_next = chd_pkg::PH_TR_LF;
        end
      end
      chd_pkg::PH_TR_LF: begin
        if (byte_in != chd_pkg::ChLf) begin
          error_reason_next = chd_pkg::ErrLf;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end else begin
          phase_next = chd_pkg::PH_TR_START;
        end
      end
      chd_pkg::PH_FINAL_LF: begin
        if (byte_in != chd_pkg::ChLf) begin
          error_reason_next = chd_pkg::ErrLf;
          phase_next        = chd_pkg::PH_ERROR;
          kind              = chd_pkg::KindError;
        end else begin
          phase_next = chd_pkg::PH_DONE;
          kind       = chd_pkg::KindEnd;
        end
      end
      chd_pkg::PH_DONE: begin
        kind = chd_pkg::KindIgnored;
      end
      default: begin
        phase_next = chd_pkg::PH_ERROR;
        kind       = chd_pkg::KindError;
      end
    endcase
    res.data = data;
    res.kind = kind;
    res.last = last;
    res.err  = (kind == chd_pkg::KindError) ? error_reason_next : chd_pkg::ErrNone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= chd_pkg::PH_SIZE_FIRST;
      remaining_count <= '0;
      error_reason    <= chd_pkg::ErrNone;
    end else if (advance) begin
      phase           <= phase_next;
      remaining_count <= remaining_count_next;
      error_reason    <= error_reason_next;
    end
  end

  // payload phase is only entered with a nonzero count and left when it hits zero
  assert property (@(posedge clk) disable iff (rst)
    phase == chd_pkg::PH_PAYLOAD |-> remaining_count != '0)
    else $error("payload phase with zero count");

  assert property (@(posedge clk) disable iff (rst)
    phase == chd_pkg::PH_ERROR |-> error_reason != chd_pkg::ErrNone)
    else $error("error phase without reason");

  assert property (@(posedge clk) disable iff (rst)
    phase == chd_pkg::PH_DONE |=> phase == chd_pkg::PH_DONE)
    else $error("left done phase");

  assert property (@(posedge clk) disable iff (rst)
    advance && res.kind == chd_pkg::KindError |=> phase == chd_pkg::PH_ERROR)
    else $error("error result without error phase");

endmodule

// ===== rtl/core/http_chunked_decoder_unit.sv =====
// An input transfer's result passes the input register, then the result
// register. One byte per cycle unless m_tready stalls the output; the framing
// phase and chunk count update in the same cycle that the result register
// loads.
// Reset (rst, synchronous): phase returns to the first size digit, count and
// error reason clear, input and output stages empty.
module http_chunked_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_out
  output logic       m_tlast,   // chunk_last
  output logic [5:0] m_tuser    // [2:0] result_kind, [5:3] error_kind
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  chd_pkg::result_t res;
  chd_pkg::result_t out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  chd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = out_res.data;
  assign m_tlast = out_res.last;
  assign m_tuser = {out_res.err, out_res.kind};

endmodule
